// ===== hw/rtl/ccct_pkg.sv =====
// ----------------------------------------------------------------------------
// ccct_pkg
// Shared constants and helper functions for the clique complex collapse test.
// ----------------------------------------------------------------------------
`default_nettype none

package ccct_pkg;

  localparam int MAX_VERTICES_DEF = 10;
  localparam int VCNT_W           = 4;
  localparam int EDGE_W           = 45;
  localparam int NUM_W            = 11;
  localparam int COLLAPSE_LIMIT   = 2;

  // population count of a mask of up to 16 bits
  function automatic logic [4:0] pcnt(input logic [15:0] v);
    logic [4:0] c;
    c = '0;
    for (int k = 0; k < 16; k++) begin
      c = c + 5'(v[k]);
    end
    return c;
  endfunction

  // a is a strict subset of b
  function automatic logic strict_sub(input logic [15:0] a, input logic [15:0] b);
    return ((a & b) == a) && (a != b);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ccct_ram.sv =====
// ----------------------------------------------------------------------------
// ccct_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ccct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ccct_clique.sv =====
// ----------------------------------------------------------------------------
// ccct_clique
// Checks whether a vertex set is a clique of the registered adjacency matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module ccct_clique #(
  parameter int NV = ccct_pkg::MAX_VERTICES_DEF
) (
  input  wire logic [NV-1:0]         mask,
  input  wire logic [NV-1:0][NV-1:0] adj,
  output logic                       is_clique
);

  always_comb begin
    is_clique = 1'b1;
    for (int p = 0; p < NV; p++) begin
      if (mask[p] && ((mask & ~(NV'(1) << p) & ~adj[p]) != '0)) begin
        is_clique = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/clique_complex_collapse_test.sv =====
// ----------------------------------------------------------------------------
// clique_complex_collapse_test
// Greedy elementary collapse of the clique complex of a small graph.
// ----------------------------------------------------------------------------
// Usage: drive in_vertex_count / in_edge_code and pulse start while busy is
// low. The request is taken at that edge; busy stays high until the result
// has been issued. The result (out_collapsible, out_simplex_total,
// out_simplices_left) is shown for exactly one cycle with out_valid high;
// the receiver cannot stall it.
// Latency depends on the graph: enumeration visits every vertex mask once
// per simplex size, coface counting scans all later simplices for each one,
// and each removed pair costs one restart of the top-down free-face search
// (a read per probed simplex plus its coface scan) and one full update sweep.
// All work goes through the single simplex RAM, one read and one write per
// cycle, which sets the rate.
// Reset (synchronous, rst_n low) returns the controller to idle; RAM
// contents are not cleared, every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module clique_complex_collapse_test #(
  parameter int MAX_VERTICES = ccct_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ccct_pkg::VCNT_W-1:0]  in_vertex_count,
  input  wire logic [ccct_pkg::EDGE_W-1:0]  in_edge_code,
  output logic                              out_valid,
  output logic                              out_collapsible,
  output logic [ccct_pkg::NUM_W-1:0]        out_simplex_total,
  output logic [ccct_pkg::NUM_W-1:0]        out_simplices_left
);

  localparam int NV     = MAX_VERTICES;
  localparam int ADDR_W = NV;
  localparam int CNT_W  = NV + 1;
  localparam int DEPTH  = 1 << NV;
  localparam int WW     = 1 + CNT_W + NV;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ENUM   = 4'd1;
  localparam logic [3:0] S_IRD    = 4'd2;
  localparam logic [3:0] S_IGET   = 4'd3;
  localparam logic [3:0] S_ISCAN  = 4'd4;
  localparam logic [3:0] S_CSTART = 4'd5;
  localparam logic [3:0] S_CRD    = 4'd6;
  localparam logic [3:0] S_CGET   = 4'd7;
  localparam logic [3:0] S_JSCAN  = 4'd8;
  localparam logic [3:0] S_DROP   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]                    state_r, state_nxt;
  logic [ccct_pkg::VCNT_W-1:0]   n_r, n_nxt, s_r, s_nxt, n_sat;
  logic [NV-1:0][NV-1:0]         adj_r, adj_nxt, adj_in;
  logic [NV-1:0]                 m_r, m_nxt, full_in, full_cur;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt, rem_r, rem_nxt;
  logic [CNT_W-1:0]              c_r, c_nxt, rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0]             i_r, i_nxt, j_r, j_nxt, tag_r, tag_nxt;
  logic [NV-1:0]                 mi_r, mi_nxt, mj_r, mj_nxt;
  logic [4:0]                    mi_sz_r, mi_sz_nxt;
  logic                          pend_r, pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          coll_r, coll_nxt;
  logic [ccct_pkg::NUM_W-1:0]    tot_r, tot_nxt, left_r, left_nxt;

  logic                          we;
  logic [ADDR_W-1:0]             waddr, raddr;
  logic [WW-1:0]                 wdata, rdata;
  logic                          issue, m_ok;
  logic [NV-1:0]                 r_mask;
  logic [CNT_W-1:0]              r_cf;
  logic                          r_alive;
  logic [1:0]                    dec;
  int                            b;

  assign r_mask  = rdata[NV-1:0];
  assign r_cf    = rdata[NV +: CNT_W];
  assign r_alive = rdata[WW-1];

  ccct_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ccct_clique #(.NV(NV)) u_clique (
    .mask      (m_r),
    .adj       (adj_r),
    .is_clique (m_ok)
  );

  // request decode: saturated vertex count and adjacency matrix
  always_comb begin
    n_sat = (in_vertex_count > ccct_pkg::VCNT_W'(NV)) ? ccct_pkg::VCNT_W'(NV)
                                                       : in_vertex_count;
    full_in  = NV'((CNT_W'(1) << n_sat) - CNT_W'(1));
    full_cur = NV'((CNT_W'(1) << n_r) - CNT_W'(1));
    adj_in = '0;
    b = 0;
    for (int p = 1; p < NV; p++) begin
      for (int q = 0; q < p; q++) begin
        b = p * (p - 1) / 2 + q;
        if (b < ccct_pkg::EDGE_W && p < int'(n_sat)) begin
          if (in_edge_code[b]) begin
            adj_in[p][q] = 1'b1;
            adj_in[q][p] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    adj_nxt       = adj_r;
    m_nxt         = m_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    c_nxt         = c_r;
    rd_addr_nxt   = rd_addr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    tag_nxt       = tag_r;
    mi_nxt        = mi_r;
    mj_nxt        = mj_r;
    mi_sz_nxt     = mi_sz_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    coll_nxt      = coll_r;
    tot_nxt       = tot_r;
    left_nxt      = left_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = i_r;
    issue         = 1'b0;
    dec           = '0;

    // streaming reads in the scan states; data returns in the following cycle
    if (state_r == S_ISCAN || state_r == S_DROP) begin
      issue = rd_addr_r < cnt_r;
      raddr = rd_addr_r[ADDR_W-1:0];
      if (issue) begin
        rd_addr_nxt = rd_addr_r + CNT_W'(1);
      end
    end else if (state_r == S_JSCAN) begin
      issue = rd_addr_r > CNT_W'(i_r);
      raddr = rd_addr_r[ADDR_W-1:0];
      if (issue) begin
        rd_addr_nxt = rd_addr_r - CNT_W'(1);
      end
    end
    if (issue) begin
      tag_nxt  = rd_addr_r[ADDR_W-1:0];
      pend_nxt = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt     = n_sat;
          adj_nxt   = adj_in;
          m_nxt     = full_in;
          s_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_ENUM;
        end
      end
      S_ENUM: begin
        if (ccct_pkg::pcnt(16'(m_r)) == 5'(s_r) && m_ok) begin
          we      = 1'b1;
          waddr   = cnt_r[ADDR_W-1:0];
          wdata   = {1'b0, CNT_W'(0), m_r};
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (m_r == '0) begin
          if (s_r == n_r) begin
            i_nxt     = '0;
            state_nxt = S_IRD;
          end else begin
            s_nxt = s_r + ccct_pkg::VCNT_W'(1);
            m_nxt = full_cur;
          end
        end else begin
          m_nxt = m_r - NV'(1);
        end
      end
      S_IRD: begin
        state_nxt = S_IGET;
      end
      S_IGET: begin
        mi_nxt      = r_mask;
        c_nxt       = '0;
        rd_addr_nxt = CNT_W'(i_r) + CNT_W'(1);
        state_nxt   = S_ISCAN;
      end
      S_ISCAN: begin
        if (pend_r) begin
          if (ccct_pkg::strict_sub(16'(mi_r), 16'(r_mask))) begin
            c_nxt = c_r + CNT_W'(1);
          end
        end else if (!issue) begin
          we    = 1'b1;
          waddr = i_r;
          wdata = {1'b1, c_r, mi_r};
          if (CNT_W'(i_r) + CNT_W'(1) == cnt_r) begin
            rem_nxt   = cnt_r;
            state_nxt = S_CSTART;
          end else begin
            i_nxt     = i_r + ADDR_W'(1);
            state_nxt = S_IRD;
          end
        end
      end
      S_CSTART: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = ADDR_W'(cnt_r - CNT_W'(1));
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        state_nxt = S_CGET;
      end
      S_CGET: begin
        if (r_alive && r_cf == CNT_W'(1)) begin
          mi_nxt      = r_mask;
          mi_sz_nxt   = ccct_pkg::pcnt(16'(r_mask));
          rd_addr_nxt = cnt_r - CNT_W'(1);
          state_nxt   = S_JSCAN;
        end else if (i_r == ADDR_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r - ADDR_W'(1);
          state_nxt = S_CRD;
        end
      end
      S_JSCAN: begin
        // first live strict superset from the top decides for this face
        if (pend_r && r_alive && ccct_pkg::strict_sub(16'(mi_r), 16'(r_mask))) begin
          pend_nxt = 1'b0;
          if (ccct_pkg::pcnt(16'(r_mask)) == mi_sz_r + 5'd1) begin
            mj_nxt      = r_mask;
            j_nxt       = tag_r;
            rd_addr_nxt = '0;
            state_nxt   = S_DROP;
          end else if (i_r == ADDR_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r - ADDR_W'(1);
            state_nxt = S_CRD;
          end
        end else if (!pend_r && !issue) begin
          if (i_r == ADDR_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r - ADDR_W'(1);
            state_nxt = S_CRD;
          end
        end
      end
      S_DROP: begin
        // remove both faces of the pair and update coface counts in one sweep
        if (pend_r) begin
          dec = 2'(ccct_pkg::strict_sub(16'(r_mask), 16'(mi_r)))
              + 2'(ccct_pkg::strict_sub(16'(r_mask), 16'(mj_r)));
          we    = 1'b1;
          waddr = tag_r;
          wdata = {r_alive && tag_r != i_r && tag_r != j_r,
                   (r_cf >= CNT_W'(dec)) ? r_cf - CNT_W'(dec) : CNT_W'(0),
                   r_mask};
        end else if (!issue) begin
          rem_nxt   = rem_r - CNT_W'(2);
          state_nxt = S_CSTART;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        coll_nxt      = rem_r <= CNT_W'(ccct_pkg::COLLAPSE_LIMIT);
        tot_nxt       = ccct_pkg::NUM_W'(cnt_r);
        left_nxt      = ccct_pkg::NUM_W'(rem_r);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    s_r       <= s_nxt;
    adj_r     <= adj_nxt;
    m_r       <= m_nxt;
    c_r       <= c_nxt;
    rd_addr_r <= rd_addr_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    tag_r     <= tag_nxt;
    mi_r      <= mi_nxt;
    mj_r      <= mj_nxt;
    mi_sz_r   <= mi_sz_nxt;
    coll_r    <= coll_nxt;
    tot_r     <= tot_nxt;
    left_r    <= left_nxt;
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_collapsible    = coll_r;
  assign out_simplex_total  = tot_r;
  assign out_simplices_left = left_r;

  // pairs are removed, so the parity of the count never changes
  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_simplices_left[0] == out_simplex_total[0])
    else $error("simplices_left parity differs from simplex_total");

  a_left_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_simplices_left <= out_simplex_total)
    else $error("more simplices left than built");

  a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted request did not raise busy");

  a_drop_write: assert property (@(posedge clk) disable iff (!rst_n)
    we && state_r == S_DROP |-> $past(issue))
    else $error("update sweep wrote without a matching read");

endmodule

`default_nettype wire
